[hdl/point_cloud_normalizer_top_defines.svh]
// Assertion macros shared by the point cloud normalizer RTL.
`ifndef POINT_CLOUD_NORMALIZER_TOP_DEFINES_SVH
`define POINT_CLOUD_NORMALIZER_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define PTCN_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PTCN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PTCN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ptcn_pkg.sv]
// Shared constants, types and helper functions of the point cloud normalizer.
`timescale 1ns / 1ps
package ptcn_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int CRD_W      = 32;
  localparam int FEAT_W     = 16;
  localparam int SUM_W      = 44;
  localparam int NUM_W      = 34;
  localparam int DEN_W      = 32;
  localparam int DIV_W      = 50;
  localparam int PROD_W     = 46;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_MEAN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_MEAN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_MEAN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_STD_0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_STD_1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_STD_2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MEAN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_STD  = 3'd7;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       rd_empty;
    logic       mean_mul;
    logic       mean_start;
    logic       mean_store;
    logic       set_ready;
    logic       fetch;
    logic       div_start;
    logic       div_store;
    logic       push;
    logic [1:0] sel;
  } ptcn_cmd_t;

  typedef struct packed {
    logic stats_ready;
    logic cloud_empty;
    logic div_done;
    logic out_free;
  } ptcn_sts_t;

  function automatic logic [31:0] sat_num(input logic signed [NUM_W-1:0] v);
    logic [31:0] r;
    if (v > NUM_W'(signed'(32'sh7fffffff))) r = 32'h7fffffff;
    else if (v < NUM_W'(signed'(32'sh80000000))) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat_quot(input logic neg, input logic [DIV_W-1:0] q);
    logic [31:0] r;
    if (neg) begin
      if (q > DIV_W'(33'h080000000)) r = 32'h80000000;
      else r = 32'(-q[31:0]);
    end else begin
      if (q > DIV_W'(32'h7fffffff)) r = 32'h7fffffff;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/ptcn_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ptcn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ptcn_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ptcn_div
  import ptcn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[DIV_W-1]};
    if (start_i) begin
      cnt_d  = CW'(DIV_W);
      busy_d = 1'b1;
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[hdl/ptcn_dp.sv]
// Datapath: point stores, cloud statistics, shared divider and result registers.
`timescale 1ns / 1ps
`include "point_cloud_normalizer_top_defines.svh"
module ptcn_dp
  import ptcn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptcn_cmd_t            cmd_i,
  output ptcn_sts_t            sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [CRD_W-1:0]     coord_x_i,
  input  logic [CRD_W-1:0]     coord_y_i,
  input  logic [CRD_W-1:0]     coord_z_i,
  input  logic [FEAT_W-1:0]    feat_0_i,
  input  logic [FEAT_W-1:0]    feat_1_i,
  input  logic [FEAT_W-1:0]    feat_2_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          pos_x_o,
  output logic [31:0]          pos_y_o,
  output logic [31:0]          pos_z_o,
  output logic [31:0]          norm_feat_0_o,
  output logic [31:0]          norm_feat_1_o,
  output logic [31:0]          norm_feat_2_o,
  output logic [31:0]          norm_height_o,
  output logic [ADDR_W-1:0]    point_index_o,
  output logic                 last_o,
  output logic                 empty_res_o
);

  logic signed [FEAT_W-1:0] fmean_q [3];
  logic [FEAT_W-1:0]        fstd_q [3];
  logic signed [31:0]       hmean_q;
  logic [31:0]              hstd_q;

  logic [CNT_W-1:0]         count_q, rptr_q;
  logic signed [CRD_W-1:0]  min_q [3];
  logic signed [SUM_W-1:0]  sum_q [3];
  logic [CRD_W-1:0]         mean_q [3];
  logic                     ready_q;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [NUM_W-1:0]  num_q [4];
  logic [31:0]              res_pos_q [3];
  logic [31:0]              res_norm_q [4];
  logic [ADDR_W-1:0]        res_idx_q;
  logic                     res_last_q, res_empty_q;

  logic                     out_valid_q;
  logic [31:0]              out_pos_q [3];
  logic [31:0]              out_norm_q [4];
  logic [ADDR_W-1:0]        out_idx_q;
  logic                     out_last_q, out_empty_q;

  logic signed [CRD_W-1:0]  in_crd [3];
  logic signed [CRD_W-1:0]  rd_crd [3];
  logic [3*FEAT_W-1:0]      rd_feat;
  logic                     load_ok;

  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_dividend, div_quot;
  logic [DEN_W-1:0]         div_den;
  logic signed [PROD_W-1:0] mean_num;
  logic [DEN_W-1:0]         std_sel;
  logic [NUM_W-1:0]         num_mag;

  assign in_crd[0] = signed'(coord_x_i);
  assign in_crd[1] = signed'(coord_y_i);
  assign in_crd[2] = signed'(coord_z_i);
  assign load_ok   = cmd_i.load && !ready_q && (count_q < CNT_W'(MAX_POINTS));

  ptcn_ram #(.WIDTH(CRD_W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk_i, .we_i(load_ok), .waddr_i(count_q[ADDR_W-1:0]), .wdata_i(coord_x_i),
    .raddr_i(rptr_q[ADDR_W-1:0]), .rdata_o(rd_crd[0])
  );
  ptcn_ram #(.WIDTH(CRD_W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk_i, .we_i(load_ok), .waddr_i(count_q[ADDR_W-1:0]), .wdata_i(coord_y_i),
    .raddr_i(rptr_q[ADDR_W-1:0]), .rdata_o(rd_crd[1])
  );
  ptcn_ram #(.WIDTH(CRD_W), .DEPTH(MAX_POINTS)) u_ram_z (
    .clk_i, .we_i(load_ok), .waddr_i(count_q[ADDR_W-1:0]), .wdata_i(coord_z_i),
    .raddr_i(rptr_q[ADDR_W-1:0]), .rdata_o(rd_crd[2])
  );
  ptcn_ram #(.WIDTH(3*FEAT_W), .DEPTH(MAX_POINTS)) u_ram_feat (
    .clk_i, .we_i(load_ok), .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i({feat_2_i, feat_1_i, feat_0_i}),
    .raddr_i(rptr_q[ADDR_W-1:0]), .rdata_o(rd_feat)
  );

  // divider operand select: cloud mean or normalization quotient
  always_comb begin
    mean_num = PROD_W'(sum_q[cmd_i.sel]) - prod_q;
    std_sel  = (cmd_i.sel == 2'd3) ? hstd_q : DEN_W'(fstd_q[cmd_i.sel]);
    if (std_sel == '0) std_sel = DEN_W'(1);
    num_mag  = num_q[cmd_i.sel][NUM_W-1] ? NUM_W'(-num_q[cmd_i.sel])
                                          : NUM_W'(num_q[cmd_i.sel]);
    if (cmd_i.mean_start) begin
      div_dividend = DIV_W'(mean_num[PROD_W-2:0]) + DIV_W'(count_q >> 1);
      div_den      = DEN_W'(count_q);
    end else begin
      div_dividend = {num_mag, 16'b0} + DIV_W'(std_sel >> 1);
      div_den      = std_sel;
    end
  end

  assign div_start = cmd_i.mean_start | cmd_i.div_start;

  ptcn_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(div_den), .done_o(div_done), .quot_o(div_quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        fmean_q[i] <= '0;
        fstd_q[i]  <= FEAT_W'(256);
      end
      hmean_q <= '0;
      hstd_q  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FEAT_MEAN_0: fmean_q[0] <= cfg_data_i[FEAT_W-1:0];
        CFG_FEAT_MEAN_1: fmean_q[1] <= cfg_data_i[FEAT_W-1:0];
        CFG_FEAT_MEAN_2: fmean_q[2] <= cfg_data_i[FEAT_W-1:0];
        CFG_FEAT_STD_0:  fstd_q[0]  <= cfg_data_i[FEAT_W-1:0];
        CFG_FEAT_STD_1:  fstd_q[1]  <= cfg_data_i[FEAT_W-1:0];
        CFG_FEAT_STD_2:  fstd_q[2]  <= cfg_data_i[FEAT_W-1:0];
        CFG_HEIGHT_MEAN: hmean_q    <= cfg_data_i;
        CFG_HEIGHT_STD:  hstd_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // cloud state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rptr_q  <= '0;
      ready_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_q[a]  <= '0;
        sum_q[a]  <= '0;
        mean_q[a] <= '0;
      end
    end else if (cmd_i.clear) begin
      count_q <= '0;
      rptr_q  <= '0;
      ready_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_q[a]  <= '0;
        sum_q[a]  <= '0;
        mean_q[a] <= '0;
      end
    end else begin
      if (load_ok) begin
        for (int a = 0; a < 3; a++) begin
          if (count_q == '0 || in_crd[a] < min_q[a]) min_q[a] <= in_crd[a];
          sum_q[a] <= sum_q[a] + SUM_W'(in_crd[a]);
        end
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.mean_store) mean_q[cmd_i.sel] <= div_quot[CRD_W-1:0];
      if (cmd_i.set_ready) ready_q <= 1'b1;
      if (cmd_i.fetch) rptr_q <= rptr_q + CNT_W'(1);
    end
  end

  // working result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_mul) begin
      prod_q <= PROD_W'(signed'({1'b0, count_q})) * PROD_W'(min_q[cmd_i.sel]);
    end
    if (cmd_i.rd_empty) begin
      for (int a = 0; a < 3; a++) res_pos_q[a] <= '0;
      for (int k = 0; k < 4; k++) res_norm_q[k] <= '0;
      res_idx_q   <= '0;
      res_last_q  <= 1'b0;
      res_empty_q <= 1'b1;
    end
    if (cmd_i.fetch) begin
      for (int a = 0; a < 2; a++) begin
        res_pos_q[a] <= sat_num(NUM_W'(rd_crd[a]) - NUM_W'(min_q[a])
                                - NUM_W'({2'b0, mean_q[a]}));
      end
      res_pos_q[2] <= sat_num(NUM_W'(rd_crd[2]) - NUM_W'(min_q[2]));
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= NUM_W'(signed'(rd_feat[k*FEAT_W +: FEAT_W])) - NUM_W'(fmean_q[k]);
      end
      num_q[3]    <= NUM_W'(rd_crd[2]) - NUM_W'(min_q[2]) - NUM_W'(hmean_q);
      res_idx_q   <= rptr_q[ADDR_W-1:0];
      res_last_q  <= (rptr_q + CNT_W'(1)) == count_q;
      res_empty_q <= 1'b0;
    end
    if (cmd_i.div_store) begin
      res_norm_q[cmd_i.sel] <= sat_quot(num_q[cmd_i.sel][NUM_W-1], div_quot);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_pos_q   <= res_pos_q;
      out_norm_q  <= res_norm_q;
      out_idx_q   <= res_idx_q;
      out_last_q  <= res_last_q;
      out_empty_q <= res_empty_q;
    end
  end

  assign sts_o.stats_ready = ready_q;
  assign sts_o.cloud_empty = (rptr_q == count_q);
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = out_pos_q[0];
  assign pos_y_o       = out_pos_q[1];
  assign pos_z_o       = out_pos_q[2];
  assign norm_feat_0_o = out_norm_q[0];
  assign norm_feat_1_o = out_norm_q[1];
  assign norm_feat_2_o = out_norm_q[2];
  assign norm_height_o = out_norm_q[3];
  assign point_index_o = out_idx_q;
  assign last_o        = out_last_q;
  assign empty_res_o   = out_empty_q;

  `PTCN_ASSERT(a_count_range, count_q <= CNT_W'(MAX_POINTS), "point count above capacity")
  `PTCN_ASSERT(a_rptr_range, rptr_q <= count_q, "read pointer past point count")
  `PTCN_ASSERT_IMP(a_push_free, cmd_i.push, !out_valid_q || !out_stall_i, "push over held word")
  `PTCN_ASSERT_NEXT(a_fetch_ready, cmd_i.fetch, ready_q, "point fetched without statistics")

endmodule

[hdl/ptcn_ctrl.sv]
// Controller: sequences loads, clears, mean computation and per-point normalization.
`timescale 1ns / 1ps
module ptcn_ctrl
  import ptcn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  ptcn_sts_t  sts_i,
  output ptcn_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MMUL  = 3'd1;
  localparam logic [2:0] S_MDIV  = 3'd2;
  localparam logic [2:0] S_MWAIT = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_DDIV  = 3'd5;
  localparam logic [2:0] S_DWAIT = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_LOAD:  cmd_o.load  = 1'b1;
            CMD_CLEAR: cmd_o.clear = 1'b1;
            CMD_READ: begin
              if (sts_i.cloud_empty) begin
                cmd_o.rd_empty = 1'b1;
                state_d = S_PUSH;
              end else if (!sts_i.stats_ready) begin
                sel_d   = 2'd0;
                state_d = S_MMUL;
              end else begin
                state_d = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_MMUL: begin
        cmd_o.mean_mul = 1'b1;
        state_d = S_MDIV;
      end
      S_MDIV: begin
        cmd_o.mean_start = 1'b1;
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.mean_store = 1'b1;
          if (sel_q == 2'd2) begin
            cmd_o.set_ready = 1'b1;
            state_d = S_FETCH;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = S_MMUL;
          end
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        sel_d   = 2'd0;
        state_d = S_DDIV;
      end
      S_DDIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (sel_q == 2'd3) begin
            state_d = S_PUSH;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = S_DDIV;
          end
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[hdl/point_cloud_normalizer_top.sv]
// Top level of the point cloud normalizer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | cmd, coord_x/y/z, feat_0..2
//  out     | source    | out_valid_o/out_stall_i| pos_x/y/z, norm_*, point_index, flags
//  cfg     | sink      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Load, clear and no-op words never stall the input. A read runs one shared 50-step
// bit-serial divider once for each of its four quotients; the first read of a cloud
// also runs it once for each of the three axis means. An empty read uses no divider.
// The input stalls while a read is in work; a finished word waits in the output
// register while the next input word is taken. Reset is asynchronous, active low;
// the point stores need no clearing.
`timescale 1ns / 1ps
module point_cloud_normalizer_top
  import ptcn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [CRD_W-1:0]     coord_x_i,
  input  logic [CRD_W-1:0]     coord_y_i,
  input  logic [CRD_W-1:0]     coord_z_i,
  input  logic [FEAT_W-1:0]    feat_0_i,
  input  logic [FEAT_W-1:0]    feat_1_i,
  input  logic [FEAT_W-1:0]    feat_2_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          pos_x_o,
  output logic [31:0]          pos_y_o,
  output logic [31:0]          pos_z_o,
  output logic [31:0]          norm_feat_0_o,
  output logic [31:0]          norm_feat_1_o,
  output logic [31:0]          norm_feat_2_o,
  output logic [31:0]          norm_height_o,
  output logic [ADDR_W-1:0]    point_index_o,
  output logic                 last_o,
  output logic                 empty_res_o
);

  ptcn_cmd_t ctl_cmd;
  ptcn_sts_t dp_sts;

  ptcn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i,
    .sts_i(dp_sts), .cmd_o(ctl_cmd)
  );

  ptcn_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(ctl_cmd), .sts_o(dp_sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .feat_0_i, .feat_1_i, .feat_2_i,
    .out_valid_o, .out_stall_i,
    .pos_x_o, .pos_y_o, .pos_z_o,
    .norm_feat_0_o, .norm_feat_1_o, .norm_feat_2_o, .norm_height_o,
    .point_index_o, .last_o, .empty_res_o
  );

endmodule

[sim/tb_point_cloud_normalizer_top.sv]
// Self-checking testbench of the point cloud normalizer: random and directed words with prediction.
`timescale 1ns / 1ps
module tb_point_cloud_normalizer_top;
  import ptcn_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_WORDS = 270;
  localparam int BIG_CLOUD   = 200;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] x, y, z;
    logic [15:0] f0, f1, f2;
  } word_t;

  typedef struct {
    logic [31:0]       px, py, pz, nf0, nf1, nf2, nh;
    logic [ADDR_W-1:0] idx;
    logic              last, empty;
  } norm_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = CMD_NOP;
  logic [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [15:0] feat_0_i = '0, feat_1_i = '0, feat_2_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [31:0] pos_x_o, pos_y_o, pos_z_o, norm_feat_0_o, norm_feat_1_o, norm_feat_2_o;
  logic [31:0] norm_height_o;
  logic [ADDR_W-1:0] point_index_o;
  logic last_o, empty_res_o;

  point_cloud_normalizer_top dut (.*);

  word_t     pending_q[$];
  norm_res_t expected_q[$];
  int        err_cnt = 0;
  int        send_idle_pct = 37;
  int        recv_idle_pct = 62;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        cycles = 0;

  // predictor state
  logic signed [31:0] px_mem[MAX_POINTS], py_mem[MAX_POINTS], pz_mem[MAX_POINTS];
  logic signed [15:0] pf_mem[MAX_POINTS][3];
  int                 pt_count, rd_ptr;
  longint             ax_min[3], ax_sum[3], ax_mean[3];
  bit                 stats_ok;
  longint             f_mean[3], f_std[3], h_mean, h_std;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_point_cloud_normalizer_top: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint scaled_quot(input longint num, input longint den);
    longint mag, q;
    bit neg;
    neg = num < 0;
    mag = (neg ? -num : num) <<< 16;
    q = (mag + den / 2) / den;
    return neg ? -q : q;
  endfunction

  function automatic void clear_cloud();
    pt_count = 0;
    rd_ptr = 0;
    stats_ok = 0;
    for (int a = 0; a < 3; a++) begin
      ax_min[a] = 0;
      ax_sum[a] = 0;
      ax_mean[a] = 0;
    end
  endfunction

  function automatic void predict_norm(input word_t w);
    longint c[3], p[3], n, s, den;
    norm_res_t r;
    case (w.cmd)
      CMD_CLEAR: clear_cloud();
      CMD_LOAD: begin
        if (!stats_ok && pt_count < MAX_POINTS) begin
          c[0] = longint'(signed'(w.x));
          c[1] = longint'(signed'(w.y));
          c[2] = longint'(signed'(w.z));
          for (int a = 0; a < 3; a++) begin
            if (pt_count == 0 || c[a] < ax_min[a]) ax_min[a] = c[a];
            ax_sum[a] += c[a];
          end
          px_mem[pt_count] = w.x;
          py_mem[pt_count] = w.y;
          pz_mem[pt_count] = w.z;
          pf_mem[pt_count][0] = w.f0;
          pf_mem[pt_count][1] = w.f1;
          pf_mem[pt_count][2] = w.f2;
          pt_count++;
        end
      end
      CMD_READ: begin
        r = '{default: '0};
        if (pt_count == 0 || rd_ptr >= pt_count) begin
          r.empty = 1'b1;
        end else begin
          if (!stats_ok) begin
            n = pt_count;
            for (int a = 0; a < 3; a++) begin
              s = ax_sum[a] - n * ax_min[a];
              ax_mean[a] = (s + n / 2) / n;
            end
            stats_ok = 1;
          end
          c[0] = px_mem[rd_ptr];
          c[1] = py_mem[rd_ptr];
          c[2] = pz_mem[rd_ptr];
          for (int a = 0; a < 3; a++) p[a] = (c[a] - ax_min[a]) - ax_mean[a];
          p[2] += ax_mean[2];
          r.px = sat32(p[0]);
          r.py = sat32(p[1]);
          r.pz = sat32(p[2]);
          den = f_std[0] < 1 ? 1 : f_std[0];
          r.nf0 = sat32(scaled_quot(longint'(pf_mem[rd_ptr][0]) - f_mean[0], den));
          den = f_std[1] < 1 ? 1 : f_std[1];
          r.nf1 = sat32(scaled_quot(longint'(pf_mem[rd_ptr][1]) - f_mean[1], den));
          den = f_std[2] < 1 ? 1 : f_std[2];
          r.nf2 = sat32(scaled_quot(longint'(pf_mem[rd_ptr][2]) - f_mean[2], den));
          den = h_std < 1 ? 1 : h_std;
          r.nh = sat32(scaled_quot(p[2] - h_mean, den));
          r.idx = rd_ptr[ADDR_W-1:0];
          r.last = (rd_ptr + 1 == pt_count);
          rd_ptr++;
        end
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    bit    take;
    word_t w;
    take = in_valid_i && !in_stall_o;
    if (take) begin
      w.cmd = cmd_i;
      w.x = coord_x_i;
      w.y = coord_y_i;
      w.z = coord_z_i;
      w.f0 = feat_0_i;
      w.f1 = feat_1_i;
      w.f2 = feat_2_i;
      predict_norm(w);
    end
    if (rst_ni && (take || !in_valid_i) && pending_q.size() > 0
        && $urandom_range(99) >= send_idle_pct) begin
      w = pending_q.pop_front();
      in_valid_i <= 1'b1;
      cmd_i <= w.cmd;
      coord_x_i <= w.x;
      coord_y_i <= w.y;
      coord_z_i <= w.z;
      feat_0_i <= w.f0;
      feat_1_i <= w.f1;
      feat_2_i <= w.f2;
    end else if (take) begin
      in_valid_i <= 1'b0;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // monitor and output stall
  always @(posedge clk_i) begin
    norm_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        check_field("pos_x", e.px, pos_x_o);
        check_field("pos_y", e.py, pos_y_o);
        check_field("pos_z", e.pz, pos_z_o);
        check_field("norm_feat_0", e.nf0, norm_feat_0_o);
        check_field("norm_feat_1", e.nf1, norm_feat_1_o);
        check_field("norm_feat_2", e.nf2, norm_feat_2_o);
        check_field("norm_height", e.nh, norm_height_o);
        check_field("point_index", 32'(e.idx), 32'(point_index_o));
        check_field("last", 32'(e.last), 32'(last_o));
        check_field("empty_res", 32'(e.empty), 32'(empty_res_o));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [31:0] rnd32();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rnd16();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [1:0] cmd, input logic [31:0] x, y, z,
                           input logic [15:0] f0, f1, f2);
    word_t w;
    w.cmd = cmd;
    w.x = x;
    w.y = y;
    w.z = z;
    w.f0 = f0;
    w.f1 = f1;
    w.f2 = f2;
    pending_q.push_back(w);
  endtask

  task automatic push_cmd(input logic [1:0] cmd);
    push_word(cmd, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic push_load();
    push_word(CMD_LOAD, rnd32(), rnd32(), rnd32(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_FEAT_MEAN_0: f_mean[0] = longint'(signed'(data[15:0]));
      CFG_FEAT_MEAN_1: f_mean[1] = longint'(signed'(data[15:0]));
      CFG_FEAT_MEAN_2: f_mean[2] = longint'(signed'(data[15:0]));
      CFG_FEAT_STD_0:  f_std[0] = longint'(data[15:0]);
      CFG_FEAT_STD_1:  f_std[1] = longint'(data[15:0]);
      CFG_FEAT_STD_2:  f_std[2] = longint'(data[15:0]);
      CFG_HEIGHT_MEAN: h_mean = longint'(signed'(data));
      default:         h_std = longint'(data);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_std();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return $urandom_range(1024);
      default: return $urandom;
    endcase
  endfunction

  task automatic set_config(input int kind);
    for (int i = 0; i < 8; i++) begin
      logic [31:0] v;
      case (kind)
        0: v = (i < 3) ? 32'h8000 : (i < 6) ? 32'h0 : (i == 6) ? 32'h80000000 : 32'h0;
        1: v = (i < 3) ? 32'h7fff : (i < 6) ? 32'hffff : (i == 6) ? 32'h7fffffff : 32'hffffffff;
        default: v = (i < 3 || i == 6) ? $urandom : rnd_std();
      endcase
      write_reg(CFG_IDX_W'(i), v);
    end
  endtask

  task automatic random_cloud();
    int n;
    if ($urandom_range(9) != 0) push_cmd(CMD_CLEAR);
    n = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      push_load();
      if ($urandom_range(15) == 0) push_cmd(CMD_NOP);
    end
    for (int i = 0; i < n + $urandom_range(2); i++) begin
      push_cmd(CMD_READ);
      if ($urandom_range(9) == 0) push_load();
      if ($urandom_range(15) == 0) push_cmd(CMD_NOP);
    end
  endtask

  initial begin
    f_mean = '{0, 0, 0};
    f_std = '{256, 256, 256};
    h_mean = 0;
    h_std = 65536;
    clear_cloud();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 62;
        recv_idle_pct = 37;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph > 0) set_config(ph - 1);
      if (ph == 0) begin
        push_cmd(CMD_READ);
        push_word(CMD_LOAD, 32'h7fffffff, 32'h80000000, 32'h0, 16'h7fff, 16'h8000, 16'h0);
        push_word(CMD_LOAD, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  16'h8000, 16'h7fff, 16'hffff);
        push_word(CMD_LOAD, 32'h0, 32'h0, 32'h80000000, 16'h0, 16'h0, 16'h7fff);
        repeat (4) push_cmd(CMD_READ);
        push_load();
        push_cmd(CMD_NOP);
        push_cmd(CMD_CLEAR);
        push_cmd(CMD_READ);
        push_load();
        push_cmd(CMD_READ);
        push_cmd(CMD_READ);
      end
      if (ph == 1) begin
        push_cmd(CMD_CLEAR);
        for (int i = 0; i < BIG_CLOUD; i++) push_load();
        repeat (3) push_cmd(CMD_READ);
        push_cmd(CMD_CLEAR);
      end
      if (ph == 2) hold_req++;
      while (pending_q.size() < PHASE_WORDS && ph != 1) random_cloud();
      if (ph == 1) repeat (20) random_cloud();
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("tb_point_cloud_normalizer_top: PASS");
    end else begin
      $display("tb_point_cloud_normalizer_top: FAIL");
    end
    $finish;
  end

endmodule
